/* sv/polled_timer_table_unit_assert.svh */
// Assertion macros shared by the timer table checker.
`ifndef POLLED_TIMER_TABLE_UNIT_ASSERT_SVH
`define POLLED_TIMER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define PTT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polled timer table check failed");

// Next-cycle implication under a synchronous reset.
`define PTT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polled timer table check failed");

`endif

/* sv/ptt_pkg.sv */
// Shared types and constants of the polled timer table.
package ptt_pkg;

   // Field widths.
   localparam int ACTION_W   = 3;
   localparam int TIDX_W     = 8;
   localparam int DATA_W     = 32;
   localparam int RSP_IDX_W  = 4;
   localparam int TIU_W      = 5;
   localparam int TICK_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TIMERS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MS_PER_TICK   = 1'b1;

   // Reset value of the tick size.
   localparam logic [TICK_W-1:0] MS_PER_TICK_RESET = 4'd1;

   // Action codes of an input beat.
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK    = 3'd0,
      ACT_START   = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_POLL    = 3'd3,
      ACT_RESTART = 3'd4
   } ptt_action_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ptt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan_step;
      logic finish;
   } ptt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hold;
      logic is_poll;
      logic count_zero;
      logic hit;
      logic pend_valid;
      logic scan_end;
   } ptt_sts_type;

endpackage

/* sv/ptt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ptt_ctrl.sv */
// Controller state machine of the polled timer table.
module ptt_ctrl import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  ptt_sts_type sts,
   output logic        req_stall,
   output ptt_cmd_type cmd
);

   ptt_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !sts.hold && sts.is_poll) begin
               state_in = sts.count_zero ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!(sts.hit && sts.pend_valid && sts.hold) && sts.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!sts.hold) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands. A scan step waits only when a second expiry finds the
   // output register still occupied.
   always_comb begin
      req_stall     = 1'b1;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = sts.hold;
            cmd.accept = req_valid && !sts.hold;
         end
         ST_SCAN: begin
            cmd.scan_step = !(sts.hit && sts.pend_valid && sts.hold);
         end
         ST_FINISH: begin
            cmd.finish = !sts.hold;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* sv/ptt_dp.sv */
// Datapath of the polled timer table: counter, entry stores, scan and output.
module ptt_dp import ptt_pkg::*; #(
   parameter int MAX_TIMERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_cmd_type           cmd,
   output ptt_sts_type           sts,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TIDX_W-1:0]     req_timer_index,
   input  logic [DATA_W-1:0]     req_timeout_ms,
   input  logic [DATA_W-1:0]     req_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic                  rsp_expired,
   output logic [RSP_IDX_W-1:0]  rsp_expired_index,
   output logic [DATA_W-1:0]     rsp_expired_tag,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W = $clog2(MAX_TIMERS + 1);
   localparam int CMP_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;

   // Configuration and counter.
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TICK_W-1:0]     mpt_ff, mpt_in;
   logic [DATA_W-1:0]     now_ff, now_in;
   logic [CMP_W-1:0]      tiu_ext, lim_ext;

   // Entry state and scan.
   logic [MAX_TIMERS-1:0] armed_ff, armed_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [DATA_W-1:0]     pend_tag_ff, pend_tag_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_expired_ff, rsp_expired_in;
   logic [RSP_IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Decode and memory signals.
   logic                  is_poll, addr_act, in_range, hold, hit, scan_end;
   logic [IDX_W-1:0]      wr_idx, rd_addr;
   logic                  rd_en, start_wr, prm_wr;
   logic [DATA_W-1:0]     start_rd, elapsed;
   logic [2*DATA_W-1:0]   prm_rd;

   assign is_poll  = (req_action == ACT_POLL);
   assign addr_act = (req_action == ACT_START) || (req_action == ACT_STOP) ||
                     (req_action == ACT_RESTART);
   assign in_range = req_timer_index < TIDX_W'(cnt_ff);
   assign wr_idx   = req_timer_index[IDX_W-1:0];
   assign hold     = rsp_valid_ff && rsp_stall;

   // Expiry test of the entry under scan, modulo 2^32.
   assign elapsed  = now_ff - start_rd;
   assign hit      = armed_ff[idx_ff] && (elapsed > prm_rd[2*DATA_W-1:DATA_W]);
   assign scan_end = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;

   assign sts.hold       = hold;
   assign sts.is_poll    = is_poll;
   assign sts.count_zero = (cnt_ff == '0);
   assign sts.hit        = hit;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.scan_end   = scan_end;

   // Entry stores: start time, and timeout with tag.
   assign start_wr = cmd.accept && in_range &&
                     ((req_action == ACT_START) || (req_action == ACT_RESTART));
   assign prm_wr   = cmd.accept && in_range && (req_action == ACT_START);
   assign rd_en    = (cmd.accept && is_poll) || (cmd.scan_step && !scan_end);
   assign rd_addr  = cmd.accept ? '0 : idx_ff + IDX_W'(1);

   ptt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TIMERS)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_wr),
      .wr_addr (wr_idx),
      .wr_data (now_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (start_rd)
   );

   ptt_ram #(.WIDTH(2*DATA_W), .DEPTH(MAX_TIMERS)) u_prm_ram (
      .clock   (clock),
      .wr_en   (prm_wr),
      .wr_addr (wr_idx),
      .wr_data ({req_timeout_ms, req_tag}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prm_rd)
   );

   // Configuration writes; the enabled count is clipped to the table size.
   assign tiu_ext = CMP_W'(csr_wdata);
   assign lim_ext = CMP_W'(MAX_TIMERS);

   always_comb begin
      cnt_in = cnt_ff;
      mpt_in = mpt_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TIMERS_IN_USE: cnt_in = CNT_W'((tiu_ext < lim_ext) ? tiu_ext : lim_ext);
            CSR_MS_PER_TICK:   mpt_in = csr_wdata[TICK_W-1:0];
            default:           cnt_in = cnt_ff;
         endcase
      end
   end

   // Millisecond counter.
   assign now_in = (cmd.accept && (req_action == ACT_TICK)) ?
                   now_ff + DATA_W'(mpt_ff) : now_ff;

   // Armed marks: set by start and restart, cleared by stop and expiry.
   always_comb begin
      armed_in = armed_ff;
      if (cmd.accept && in_range) begin
         if ((req_action == ACT_START) || (req_action == ACT_RESTART)) begin
            armed_in[wr_idx] = 1'b1;
         end else if (req_action == ACT_STOP) begin
            armed_in[wr_idx] = 1'b0;
         end
      end
      if (cmd.scan_step && hit) begin
         armed_in[idx_ff] = 1'b0;
      end
   end

   // Scan index and the expiry held back until its last flag is known.
   always_comb begin
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_tag_in   = pend_tag_ff;
      if (cmd.accept) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = idx_ff;
            pend_tag_in   = prm_rd[DATA_W-1:0];
         end
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end
   end

   // Output register loads.
   always_comb begin
      rsp_valid_in   = hold;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_last_in    = rsp_last_ff;
      priority if (cmd.accept && !is_poll) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = addr_act && !in_range;
         rsp_expired_in = 1'b0;
         rsp_index_in   = '0;
         rsp_tag_in     = '0;
         rsp_last_in    = 1'b1;
      end else if (cmd.scan_step && hit && pend_valid_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = 1'b0;
         rsp_expired_in = 1'b1;
         rsp_index_in   = RSP_IDX_W'(pend_idx_ff);
         rsp_tag_in     = pend_tag_ff;
         rsp_last_in    = 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = 1'b0;
         rsp_expired_in = pend_valid_ff;
         rsp_index_in   = pend_valid_ff ? RSP_IDX_W'(pend_idx_ff) : '0;
         rsp_tag_in     = pend_valid_ff ? pend_tag_ff : '0;
         rsp_last_in    = 1'b1;
      end else begin
         rsp_valid_in   = hold;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         mpt_ff        <= MS_PER_TICK_RESET;
         now_ff        <= '0;
         armed_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         mpt_ff        <= mpt_in;
         now_ff        <= now_in;
         armed_ff      <= armed_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired       = rsp_expired_ff;
   assign rsp_expired_index = rsp_index_ff;
   assign rsp_expired_tag   = rsp_tag_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* sv/polled_timer_table_unit.sv */
// Top level of the polled timer table: controller and datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   action, timer_index, timeout_ms, tag
//   rsp      out        rsp_valid/rsp_stall   status, expired, expired_index, expired_tag, last
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// For every action but poll, the beat is accepted and its result loads the output register
// at the same edge. In a poll, the accept primes the RAM read, then the enabled entries are
// scanned in turn, and a final beat closes the poll.
// The armed marks are flip-flops cleared by reset; there is no clearing pass.
// A stalled output beat holds off new input and, during a poll, a second expiry.
module polled_timer_table_unit import ptt_pkg::*; #(
   parameter int MAX_TIMERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TIDX_W-1:0]     req_timer_index,
   input  logic [DATA_W-1:0]     req_timeout_ms,
   input  logic [DATA_W-1:0]     req_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic                  rsp_expired,
   output logic [RSP_IDX_W-1:0]  rsp_expired_index,
   output logic [DATA_W-1:0]     rsp_expired_tag,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ptt_cmd_type cmd;
   ptt_sts_type sts;

   // Sequencer.
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Storage, compare and output register.
   ptt_dp #(.MAX_TIMERS(MAX_TIMERS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_timer_index   (req_timer_index),
      .req_timeout_ms    (req_timeout_ms),
      .req_tag           (req_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_expired       (rsp_expired),
      .rsp_expired_index (rsp_expired_index),
      .rsp_expired_tag   (rsp_expired_tag),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

/* sv/ptt_checker.sv */
// Port-level checker of the polled timer table and its bind.
`include "polled_timer_table_unit_assert.svh"

module ptt_checker import ptt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_status,
   input logic                  rsp_expired,
   input logic [RSP_IDX_W-1:0]  rsp_expired_index,
   input logic [DATA_W-1:0]     rsp_expired_tag,
   input logic                  rsp_last
);

   logic outstanding_ff, outstanding_in;

   // An accepted beat stays outstanding until its final result is taken.
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_valid && !req_stall) begin
         outstanding_in = 1'b1;
      end else if (rsp_valid && !rsp_stall && rsp_last) begin
         outstanding_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled result beat keeps its expired tag, expired index and last flag.
   `PTT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_expired_tag) && $stable(rsp_expired_index) && $stable(rsp_last))

   // No result appears without an accepted beat behind it.
   `PTT_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, outstanding_ff)

   // The input waits while a poll still has results to give.
   `PTT_ASSERT_IMP(a_busy_stall, clock, reset, outstanding_ff && !(rsp_valid && rsp_last), req_stall)

   // Rejections and empty results close their beat and report no expiry.
   `PTT_ASSERT_IMP(a_plain_last, clock, reset, rsp_valid && (rsp_status || !rsp_expired), rsp_last && !(rsp_status && rsp_expired))

endmodule

bind polled_timer_table_unit ptt_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_expired       (rsp_expired),
   .rsp_expired_index (rsp_expired_index),
   .rsp_expired_tag   (rsp_expired_tag),
   .rsp_last          (rsp_last)
);
